// File: design/sltok_pkg.sv
// Shared types, character codes and helper functions of the shell line tokenizer.
// Used by every module of the design; depends on nothing else.
package sltok_pkg;

	localparam int unsigned POSITION_BITS = 8;
	localparam int unsigned RQ_DEPTH = 4;
	localparam int unsigned RQ_PTR_BITS = $clog2(RQ_DEPTH);

	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [RQ_PTR_BITS-1:0] rq_ptr_t;
	typedef logic [RQ_PTR_BITS:0] rq_cnt_t;

	localparam pos_t POS_LIMIT = '1;
	localparam logic [7:0] MAX_TOKENS_RESET = 8'd16;

	localparam logic [7:0] CH_NUL = 8'd0;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_DQUOTE = 8'd34;
	localparam logic [7:0] CH_SQUOTE = 8'd39;
	localparam logic [7:0] CH_BSLASH = 8'd92;
	localparam logic [7:0] CH_PIPE = 8'd124;

	typedef enum logic [2:0] {
		K_CMD = 3'd0,
		K_WORD = 3'd1,
		K_PIPE = 3'd2,
		K_EOL = 3'd3,
		K_BAD = 3'd4,
		K_NONE = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		LS_CONTINUE = 2'd0,
		LS_ACCEPT = 2'd1,
		LS_REJECT = 2'd2
	} line_status_t;

	typedef enum logic [3:0] {
		M_BETWEEN = 4'b0001,
		M_WORD = 4'b0010,
		M_QUOTE = 4'b0100,
		M_DISCARD = 4'b1000
	} mode_t;

	typedef struct packed {
		mode_t mode;
		kind_t prev;
		pos_t start_pos;
		pos_t run_len;
		pos_t char_pos;
		logic [7:0] tokens;
		logic quote_dq;
		logic last_bs;
	} scan_state_t;

	localparam scan_state_t NEW_LINE_STATE = '{
		mode: M_BETWEEN,
		prev: K_NONE,
		start_pos: '0,
		run_len: '0,
		char_pos: '0,
		tokens: 8'd0,
		quote_dq: 1'b0,
		last_bs: 1'b0
	};

	typedef struct packed {
		kind_t kind;
		logic [7:0] start;
		logic [7:0] size;
		logic [7:0] number;
		line_status_t status;
		logic last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t res0;
		result_t res1;
	} push_t;

	function automatic logic is_word_char(logic [7:0] c);
		return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90) ||
			(c >= 8'd48 && c <= 8'd57) || (c == 8'd95);
	endfunction

	function automatic logic [7:0] to_byte(pos_t v);
		logic [POSITION_BITS+7:0] w;
		w = {8'd0, v};
		return w[7:0];
	endfunction

	function automatic logic [7:0] sat_inc(logic [7:0] n);
		return (n == 8'hFF) ? n : n + 8'd1;
	endfunction

	function automatic line_status_t status_of(kind_t k, logic [7:0] n, logic [7:0] lim);
		logic [8:0] n1;
		n1 = {1'b0, n} + 9'd1;
		if (k == K_BAD) begin
			return LS_REJECT;
		end else if (k == K_EOL) begin
			return (n < lim) ? LS_ACCEPT : LS_REJECT;
		end else begin
			return (n1 >= {1'b0, lim}) ? LS_REJECT : LS_CONTINUE;
		end
	endfunction

	function automatic result_t mk_result(kind_t k, logic [7:0] start, logic [7:0] size,
			logic [7:0] n, logic [7:0] lim);
		result_t r;
		r.kind = k;
		r.start = start;
		r.size = size;
		r.number = n;
		r.status = status_of(k, n, lim);
		r.last = 1'b0;
		return r;
	endfunction

endpackage

// File: design/sltok_char_if.sv
// Character channel of the shell line tokenizer: one byte of a command line per request.
// Stands alone; no package needed.
interface sltok_char_if;
	logic valid;
	logic ready;
	logic [7:0] character;

	modport source(output valid, output character, input ready);
	modport sink(input valid, input character, output ready);
endinterface

// File: design/sltok_token_if.sv
// Token channel of the shell line tokenizer: one reported token per request.
// Stands alone; no package needed.
interface sltok_token_if;
	logic valid;
	logic ready;
	logic [2:0] token_kind;
	logic [7:0] token_start;
	logic [7:0] token_length;
	logic [7:0] token_number;
	logic [1:0] line_status;
	logic last_of_run;

	modport source(output valid, output token_kind, output token_start, output token_length,
		output token_number, output line_status, output last_of_run, input ready);
	modport sink(input valid, input token_kind, input token_start, input token_length,
		input token_number, input line_status, input last_of_run, output ready);
endinterface

// File: design/sltok_cfg_if.sv
// Configuration write channel of the shell line tokenizer, carrying the token limit.
// Stands alone; no package needed.
interface sltok_cfg_if;
	logic valid;
	logic ready;
	logic [7:0] max_tokens;

	modport source(output valid, output max_tokens, input ready);
	modport sink(input valid, input max_tokens, output ready);
endinterface

// File: design/shell_line_tokenizer.sv
// Top level of the shell line tokenizer: token limit register, scan stage and result queue.
// Depends on sltok_pkg, the three channel interfaces, sltok_scan and sltok_outq.
//
// Channel  Role    Payload                                             Request
// chars    sink    character                                           one byte of a line
// tokens   source  token_kind token_start token_length token_number    one token
//                  line_status last_of_run
// cfg      sink    max_tokens                                          one limit write
//
// One character is accepted per cycle unless the channel stalls; its tokens pass the input
// register and the result queue before they can be taken. Two tokens of one character are
// handed out in turn; a four-entry queue keeps input flowing while results wait.
// The character channel stalls only when that queue cannot take two more results.
// Reset clears the line state, the queue and the input stage; the token limit returns to 16.
module shell_line_tokenizer import sltok_pkg::*; (
	input logic clk,
	input logic arst_n,
	sltok_char_if.sink chars,
	sltok_token_if.source tokens,
	sltok_cfg_if.sink cfg
);

	logic [7:0] max_tokens_q;
	logic room;
	push_t push;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tokens_q <= MAX_TOKENS_RESET;
		end else if (cfg.valid && cfg.ready) begin
			max_tokens_q <= cfg.max_tokens;
		end
	end

	sltok_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars),
		.max_tokens(max_tokens_q),
		.room(room),
		.push(push)
	);

	sltok_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.tokens(tokens)
	);

endmodule

// File: design/sltok_scan.sv
// Input register, line scan state and the per-character token logic.
// Depends on sltok_pkg and sltok_char_if; feeds up to two results to the result queue.
module sltok_scan import sltok_pkg::*; (
	input logic clk,
	input logic arst_n,
	sltok_char_if.sink chars,
	input logic [7:0] max_tokens,
	input logic room,
	output push_t push
);

	logic [7:0] chr_s1;
	logic vld_s1;
	scan_state_t state_q;
	scan_state_t nx;

	logic advance;
	logic [7:0] c;
	pos_t p;
	logic [7:0] lim;
	logic is_nul;
	logic is_lf;
	logic line_end;
	logic too_long;
	logic do_start;
	kind_t st_prev;
	kind_t word_k;
	logic [7:0] close_q;

	logic tk_emit;
	kind_t tk_kind;
	logic [7:0] tk_start;
	logic [7:0] tk_size;

	logic e0;
	logic e1;
	kind_t k0;
	kind_t k1;
	logic [7:0] start0;
	logic [7:0] start1;
	logic [7:0] size0;
	logic [7:0] size1;
	logic [7:0] n0;
	logic [7:0] n1;
	logic [7:0] n2;
	result_t r0;
	result_t r1;
	logic rejected;

	assign advance = vld_s1 && room;
	assign chars.ready = !vld_s1 || room;

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			chr_s1 <= chars.character;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			state_q <= NEW_LINE_STATE;
		end else begin
			if (chars.valid && chars.ready) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				state_q <= nx;
			end
		end
	end

	always_comb begin
		c = chr_s1;
		p = state_q.char_pos;
		lim = (max_tokens == 8'd0) ? 8'd1 : max_tokens;
		nx = state_q;
		is_nul = (c == CH_NUL);
		is_lf = (c == CH_LF);
		line_end = (state_q.mode == M_QUOTE) ? is_nul : (is_nul || is_lf);
		too_long = (state_q.mode != M_DISCARD) && (p == POS_LIMIT) && !line_end;
		word_k = (state_q.prev == K_NONE || state_q.prev == K_PIPE) ? K_CMD : K_WORD;
		close_q = state_q.quote_dq ? CH_DQUOTE : CH_SQUOTE;
		n0 = state_q.tokens;
		n1 = sat_inc(n0);
		n2 = sat_inc(n1);
		do_start = 1'b0;
		st_prev = state_q.prev;
		e0 = 1'b0;
		e1 = 1'b0;
		k0 = K_BAD;
		k1 = K_BAD;
		start0 = 8'd0;
		start1 = 8'd0;
		size0 = 8'd0;
		size1 = 8'd0;
		tk_emit = 1'b0;
		tk_kind = K_BAD;
		tk_start = 8'd0;
		tk_size = 8'd0;

		if (too_long) begin
			e0 = 1'b1;
			k0 = K_BAD;
			start0 = to_byte(p);
		end else begin
			unique case (state_q.mode)
				M_QUOTE: begin
					if (is_nul) begin
						e0 = 1'b1;
						k0 = K_BAD;
						start0 = to_byte(state_q.start_pos);
						size0 = to_byte(state_q.run_len + pos_t'(1));
					end else if (c == close_q && !state_q.last_bs) begin
						e0 = 1'b1;
						k0 = K_WORD;
						start0 = to_byte(state_q.start_pos + pos_t'(1));
						size0 = to_byte(state_q.run_len);
						nx.prev = K_WORD;
						nx.mode = M_BETWEEN;
					end else begin
						nx.run_len = state_q.run_len + pos_t'(1);
						nx.last_bs = (c == CH_BSLASH);
					end
				end
				M_WORD: begin
					if (is_word_char(c)) begin
						nx.run_len = state_q.run_len + pos_t'(1);
					end else begin
						e0 = 1'b1;
						k0 = word_k;
						start0 = to_byte(state_q.start_pos);
						size0 = to_byte(state_q.run_len);
						nx.prev = word_k;
						nx.mode = M_BETWEEN;
						st_prev = word_k;
						do_start = (status_of(word_k, n0, lim) != LS_REJECT);
					end
				end
				M_BETWEEN: begin
					do_start = 1'b1;
				end
				M_DISCARD: begin
				end
				default: begin
				end
			endcase
		end

		if (do_start) begin
			if (is_nul || is_lf) begin
				tk_emit = 1'b1;
				tk_start = to_byte(p);
				if (st_prev == K_PIPE) begin
					tk_kind = K_BAD;
					tk_size = 8'd1;
				end else begin
					tk_kind = K_EOL;
				end
			end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
				nx.mode = M_QUOTE;
				nx.quote_dq = (c == CH_DQUOTE);
				nx.last_bs = 1'b0;
				nx.start_pos = p;
				nx.run_len = '0;
			end else if (c == CH_PIPE) begin
				tk_emit = 1'b1;
				tk_start = to_byte(p);
				tk_size = 8'd1;
				if (st_prev == K_PIPE || st_prev == K_NONE) begin
					tk_kind = K_BAD;
				end else begin
					tk_kind = K_PIPE;
					nx.prev = K_PIPE;
				end
			end else if (is_word_char(c)) begin
				nx.mode = M_WORD;
				nx.start_pos = p;
				nx.run_len = pos_t'(1);
			end else if (c != CH_SPACE) begin
				tk_emit = 1'b1;
				tk_kind = K_BAD;
				tk_start = to_byte(p);
			end
		end

		if (state_q.mode == M_WORD) begin
			e1 = tk_emit;
			k1 = tk_kind;
			start1 = tk_start;
			size1 = tk_size;
		end else if (tk_emit) begin
			e0 = 1'b1;
			k0 = tk_kind;
			start0 = tk_start;
			size0 = tk_size;
		end

		r0 = mk_result(k0, start0, size0, n0, lim);
		r1 = mk_result(k1, start1, size1, n1, lim);
		if (e1) begin
			r1.last = 1'b1;
		end else begin
			r0.last = 1'b1;
		end
		rejected = (e0 && r0.status == LS_REJECT) || (e1 && r1.status == LS_REJECT);
		nx.tokens = e1 ? n2 : (e0 ? n1 : n0);

		if (state_q.mode == M_DISCARD) begin
			if (is_nul || is_lf) begin
				nx = NEW_LINE_STATE;
			end
		end else if (too_long) begin
			nx.mode = M_DISCARD;
		end else if (is_nul && (nx.mode != M_QUOTE || rejected || e0)) begin
			nx = NEW_LINE_STATE;
		end else if (is_lf && nx.mode != M_QUOTE) begin
			nx = NEW_LINE_STATE;
		end else if (rejected) begin
			nx.mode = M_DISCARD;
		end else begin
			nx.char_pos = p + pos_t'(1);
		end

		push.res0 = r0;
		push.res1 = r1;
		if (advance && e1) begin
			push.count = 2'd2;
		end else if (advance && e0) begin
			push.count = 2'd1;
		end else begin
			push.count = 2'd0;
		end
	end

endmodule

// File: design/sltok_outq.sv
// Result queue of the shell line tokenizer: takes up to two results a cycle, hands out one.
// Depends on sltok_pkg and sltok_token_if.
module sltok_outq import sltok_pkg::*; (
	input logic clk,
	input logic arst_n,
	input push_t push,
	output logic room,
	sltok_token_if.source tokens
);

	result_t entries_q [RQ_DEPTH];
	rq_ptr_t wr_ptr_q;
	rq_ptr_t rd_ptr_q;
	rq_cnt_t count_q;
	logic pop;
	result_t head;

	assign pop = tokens.valid && tokens.ready;
	assign room = (count_q - rq_cnt_t'(pop)) <= rq_cnt_t'(RQ_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entries_q[wr_ptr_q] <= push.res0;
		end
		if (push.count == 2'd2) begin
			entries_q[wr_ptr_q + rq_ptr_t'(1)] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + rq_ptr_t'(push.count);
			rd_ptr_q <= rd_ptr_q + rq_ptr_t'(pop);
			count_q <= count_q + rq_cnt_t'(push.count) - rq_cnt_t'(pop);
		end
	end

	assign head = entries_q[rd_ptr_q];
	assign tokens.valid = (count_q != '0);
	assign tokens.token_kind = head.kind;
	assign tokens.token_start = head.start;
	assign tokens.token_length = head.size;
	assign tokens.token_number = head.number;
	assign tokens.line_status = head.status;
	assign tokens.last_of_run = head.last;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of shell_line_tokenizer: streams command lines one byte per request
// and checks every reported token, in order, against a behavioral model of the scanner.
// Depends on sltok_pkg, the three channel interfaces and the design top level.
module testbench;
	import sltok_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam int PHASE_CHARS = 75;
	localparam logic [7:0] CH_LOWER_A = 8'd97;
	localparam logic [7:0] CH_UPPER_A = 8'd65;
	localparam logic [7:0] CH_DIGIT_0 = 8'd48;
	localparam logic [7:0] CH_UNDERSCORE = 8'd95;
	localparam logic [7:0] CH_LETTER_X = 8'd120;

	typedef logic [7:0] byte_q_t[$];

	logic clk;
	logic arst_n;

	sltok_char_if chars_ch();
	sltok_token_if tokens_ch();
	sltok_cfg_if cfg_ch();

	shell_line_tokenizer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars_ch),
		.tokens(tokens_ch),
		.cfg(cfg_ch)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	mode_t scan_mode;
	kind_t prev_kind;
	pos_t token_start_pos;
	pos_t run_len;
	pos_t char_pos;
	logic [7:0] token_count;
	logic [7:0] limit_reg;
	logic in_double;
	logic after_bslash;
	logic line_rejected;
	result_t step_tokens[$];
	result_t expected_tokens[$];
	int errors = 0;
	int chars_sent;
	int live_chars;
	int tokens_checked = 0;
	int limits_used;
	int idle_cycles = 0;
	bit calm;

	function automatic bit word_byte(logic [7:0] c);
		return (c >= CH_LOWER_A && c < CH_LOWER_A + 8'd26) ||
			(c >= CH_UPPER_A && c < CH_UPPER_A + 8'd26) ||
			(c >= CH_DIGIT_0 && c < CH_DIGIT_0 + 8'd10) || c == CH_UNDERSCORE;
	endfunction

	function automatic logic [7:0] rand_word_char();
		case ($urandom_range(0, 3))
			0: return CH_LOWER_A + 8'($urandom_range(0, 25));
			1: return CH_UPPER_A + 8'($urandom_range(0, 25));
			2: return CH_DIGIT_0 + 8'($urandom_range(0, 9));
			default: return CH_UNDERSCORE;
		endcase
	endfunction

	function automatic void reset_line();
		scan_mode = M_BETWEEN;
		prev_kind = K_NONE;
		token_start_pos = '0;
		run_len = '0;
		char_pos = '0;
		token_count = 8'd0;
		in_double = 1'b0;
		after_bslash = 1'b0;
	endfunction

	function automatic void add_token(kind_t kind, logic [7:0] start, logic [7:0] size);
		logic [7:0] lim;
		result_t r;
		lim = (limit_reg == 8'd0) ? 8'd1 : limit_reg;
		r.kind = kind;
		r.start = start;
		r.size = size;
		r.number = token_count;
		r.last = 1'b0;
		if (kind == K_BAD) begin
			r.status = LS_REJECT;
		end else if (kind == K_EOL) begin
			r.status = (token_count < lim) ? LS_ACCEPT : LS_REJECT;
		end else begin
			r.status = ({1'b0, token_count} + 9'd1 >= {1'b0, lim}) ? LS_REJECT : LS_CONTINUE;
		end
		if (r.status == LS_REJECT) begin
			line_rejected = 1'b1;
		end
		step_tokens.push_back(r);
		if (token_count != 8'hFF) begin
			token_count = token_count + 8'd1;
		end
	endfunction

	function automatic void open_token(logic [7:0] c, pos_t p);
		if (c == CH_NUL || c == CH_LF) begin
			if (prev_kind == K_PIPE) begin
				add_token(K_BAD, p, 8'd1);
			end else begin
				add_token(K_EOL, p, 8'd0);
			end
		end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
			scan_mode = M_QUOTE;
			in_double = (c == CH_DQUOTE);
			after_bslash = 1'b0;
			token_start_pos = p;
			run_len = '0;
		end else if (c == CH_PIPE) begin
			if (prev_kind == K_PIPE || prev_kind == K_NONE) begin
				add_token(K_BAD, p, 8'd1);
			end else begin
				add_token(K_PIPE, p, 8'd1);
				prev_kind = K_PIPE;
			end
		end else if (word_byte(c)) begin
			scan_mode = M_WORD;
			token_start_pos = p;
			run_len = 8'd1;
		end else if (c != CH_SPACE) begin
			add_token(K_BAD, p, 8'd0);
		end
	endfunction

	// Updates the scanner for one accepted byte and queues the tokens it reports.
	function automatic void predict_char(logic [7:0] c);
		pos_t p;
		logic line_end;
		kind_t k;
		p = char_pos;
		step_tokens.delete();
		line_rejected = 1'b0;
		if (scan_mode == M_DISCARD) begin
			if (c == CH_NUL || c == CH_LF) begin
				reset_line();
			end
			return;
		end
		live_chars++;
		line_end = (scan_mode == M_QUOTE) ? (c == CH_NUL) : (c == CH_NUL || c == CH_LF);
		if (p == POS_LIMIT && !line_end) begin
			add_token(K_BAD, p, 8'd0);
			scan_mode = M_DISCARD;
		end else begin
			case (scan_mode)
				M_QUOTE: begin
					if (c == CH_NUL) begin
						add_token(K_BAD, token_start_pos, run_len + 8'd1);
					end else if (c == (in_double ? CH_DQUOTE : CH_SQUOTE) && !after_bslash) begin
						add_token(K_WORD, token_start_pos + 8'd1, run_len);
						prev_kind = K_WORD;
						scan_mode = M_BETWEEN;
					end else begin
						run_len = run_len + 8'd1;
						after_bslash = (c == CH_BSLASH);
					end
				end
				M_WORD: begin
					if (word_byte(c)) begin
						run_len = run_len + 8'd1;
					end else begin
						k = (prev_kind == K_NONE || prev_kind == K_PIPE) ? K_CMD : K_WORD;
						add_token(k, token_start_pos, run_len);
						prev_kind = k;
						scan_mode = M_BETWEEN;
						if (!line_rejected) begin
							open_token(c, p);
						end
					end
				end
				default: begin
					open_token(c, p);
				end
			endcase
			if (c == CH_NUL && (scan_mode != M_QUOTE || line_rejected || step_tokens.size() > 0))
			begin
				reset_line();
			end else if (c == CH_LF && scan_mode != M_QUOTE) begin
				reset_line();
			end else if (line_rejected) begin
				scan_mode = M_DISCARD;
			end else begin
				char_pos = p + 8'd1;
			end
		end
		if (step_tokens.size() > 0) begin
			step_tokens[step_tokens.size() - 1].last = 1'b1;
		end
		foreach (step_tokens[i]) begin
			expected_tokens.push_back(step_tokens[i]);
		end
	endfunction

	task automatic send_char(logic [7:0] c);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			chars_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_ch.valid <= 1'b1;
		chars_ch.character <= c;
		do @(posedge clk); while (!chars_ch.ready);
		predict_char(c);
		chars_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i]);
		end
	endtask

	task automatic send_line(byte_q_t text);
		foreach (text[i]) begin
			send_char(text[i]);
		end
	endtask

	task automatic wait_idle();
		chars_ch.valid <= 1'b0;
		while (expected_tokens.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [7:0] value);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.max_tokens <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		limit_reg = value;
		limits_used++;
	endtask

	function automatic byte_q_t make_line();
		byte_q_t text;
		int n_items;
		logic [7:0] q;
		n_items = $urandom_range(0, 6);
		for (int i = 0; i < n_items; i++) begin
			if (i > 0 && $urandom_range(0, 4) == 0) begin
				text.push_back(CH_PIPE);
			end
			repeat ($urandom_range(0, 2)) text.push_back(CH_SPACE);
			case ($urandom_range(0, 15))
				0: begin
					text.push_back(8'($urandom_range(0, 255)));
				end
				1: begin
					text.push_back(CH_PIPE);
				end
				2, 3, 4: begin
					q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
					text.push_back(q);
					repeat ($urandom_range(0, 5)) begin
						case ($urandom_range(0, 7))
							0: begin
								text.push_back(CH_BSLASH);
								text.push_back(q);
							end
							1: text.push_back(8'($urandom_range(1, 255)));
							2: text.push_back(CH_SPACE);
							default: text.push_back(rand_word_char());
						endcase
					end
					text.push_back(q);
				end
				default: begin
					repeat ($urandom_range(1, 6)) text.push_back(rand_word_char());
				end
			endcase
			if ($urandom_range(0, 2) != 0) begin
				text.push_back(CH_SPACE);
			end
		end
		case ($urandom_range(0, 9))
			0: begin
				text.push_back($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
				repeat ($urandom_range(0, 3)) text.push_back(rand_word_char());
				text.push_back(CH_NUL);
			end
			1, 2, 3: text.push_back(CH_NUL);
			default: text.push_back(CH_LF);
		endcase
		return text;
	endfunction

	task automatic test_directed_lines();
		send_text("|\n");
		send_text("a|b|\n");
		send_text("x \"a\\\"\" 'z");
		send_char(CH_NUL);
		send_char(8'hFF);
		send_char(CH_NUL);
		send_text("\n");
	endtask

	task automatic test_token_limit();
		write_limit(8'd1);
		send_text("a\n");
		send_text("\n");
		write_limit(8'd0);
		send_text("\n");
		send_text("b c\n");
		write_limit(8'd2);
		send_text("a b\n");
		send_text("a|\n");
	endtask

	task automatic test_long_line();
		write_limit(8'd255);
		for (int round = 0; round < 2; round++) begin
			for (int i = 0; i < int'(POS_LIMIT); i++) begin
				send_char((i % 3 == 2) ? CH_SPACE : rand_word_char());
			end
			if (round == 0) begin
				send_char(CH_LETTER_X);
			end
			send_char(CH_LF);
		end
	endtask

	task automatic test_random_lines();
		logic [7:0] limits[7];
		int first;
		limits = '{8'd16, 8'd3, 8'd1, 8'd0, 8'd255, 8'd8, 8'd8};
		limits[6] = 8'($urandom_range(1, 255));
		foreach (limits[ph]) begin
			write_limit(limits[ph]);
			first = chars_sent;
			while (chars_sent - first < PHASE_CHARS) begin
				calm = ($urandom_range(0, 3) == 0);
				send_line(make_line());
				if ($urandom_range(0, 19) == 0) begin
					wait_idle();
				end
			end
			calm = 1'b0;
		end
	endtask

	initial begin : token_sink
		int stall;
		result_t want;
		tokens_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				tokens_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			tokens_ch.ready <= 1'b1;
			do @(posedge clk); while (!tokens_ch.valid);
			tokens_checked++;
			if (expected_tokens.size() == 0) begin
				errors++;
				$display("%0t: unexpected token, expected none, got kind %0d start %0d size %0d",
					$time, tokens_ch.token_kind, tokens_ch.token_start, tokens_ch.token_length);
			end else begin
				want = expected_tokens.pop_front();
				if (tokens_ch.token_kind !== want.kind || tokens_ch.token_start !== want.start ||
					tokens_ch.token_length !== want.size ||
					tokens_ch.token_number !== want.number ||
					tokens_ch.line_status !== want.status ||
					tokens_ch.last_of_run !== want.last) begin
					errors++;
					$display("%0t: expected kind %0d start %0d size %0d number %0d status %0d last %0d",
						$time, want.kind, want.start, want.size, want.number, want.status,
						want.last);
					$display("%0t:   actual kind %0d start %0d size %0d number %0d status %0d last %0d",
						$time, tokens_ch.token_kind, tokens_ch.token_start, tokens_ch.token_length,
						tokens_ch.token_number, tokens_ch.line_status, tokens_ch.last_of_run);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((chars_ch.valid && chars_ch.ready) || (tokens_ch.valid && tokens_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no request accepted for %0d cycles", $time, idle_cycles);
				$display("RESULT: ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		chars_ch.valid = 1'b0;
		chars_ch.character = 8'd0;
		cfg_ch.valid = 1'b0;
		cfg_ch.max_tokens = 8'd0;
		chars_sent = 0;
		live_chars = 0;
		limits_used = 0;
		calm = 1'b0;
		limit_reg = MAX_TOKENS_RESET;
		reset_line();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_lines();
		test_token_limit();
		test_long_line();
		test_random_lines();
		wait_idle();
		$display("Sent %0d characters (%0d scanned, rest discarded) under %0d limit writes.",
			chars_sent, live_chars, limits_used);
		$display("Compared %0d tokens; %0d mismatches.", tokens_checked, errors);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
